@@ design/afg_pkg.sv @@
// ----------------------------------------------------------------------------
// Affine grid point generator package
// Shared widths, defaults, register indexes and the pipeline side-band type.
// ----------------------------------------------------------------------------
`default_nettype none

package afg_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int MAX_DIM_DEF   = 1024;

   localparam int SIZE_W     = 11;
   localparam int IDX_W      = 10;
   localparam int COEF_W     = 32;
   localparam int NUM_COEF   = 12;
   localparam int COEF_IDX_W = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam int NUM_AXES   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THREE_D       = 3'd0,
      CSR_ALIGN_CORNERS = 3'd1,
      CSR_WIDTH         = 3'd2,
      CSR_HEIGHT        = 3'd3,
      CSR_DEPTH         = 3'd4
   } csr_index_type;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_POINT = 1'b1
   } func_type;

   // Control that rides along with each item through the divider stages.
   typedef struct packed {
      logic                  valid;
      func_type              func;
      logic                  err;
      logic [NUM_AXES-1:0]   one;
      logic [NUM_AXES-1:0]   neg;
      logic [COEF_IDX_W-1:0] coef_index;
      logic [COEF_W-1:0]     coef_value;
   } side_type;

endpackage

`default_nettype wire

@@ design/afg_div.sv @@
// ----------------------------------------------------------------------------
// Affine grid pipelined divider
// Restoring division, STEP quotient bits per register stage. The quotient
// must fit QW bits and the upper numerator bits must stay below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module afg_div #(
   parameter int QW   = 17,
   parameter int DW   = 12,
   parameter int STEP = 2
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [DW+QW-1:0] num_in,
   input  wire logic [DW-1:0]    den_in,
   output logic      [QW-1:0]    quot_out
);

   localparam int STAGES = (QW + STEP - 1) / STEP;

   logic [DW-1:0] rem_ff [STAGES];
   logic [DW-1:0] den_ff [STAGES];
   logic [QW-1:0] low_ff [STAGES];
   logic [QW-1:0] quot_ff[STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [DW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [QW-1:0] low_src;
      logic [QW-1:0] quot_src;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quot_in;

      if (s == 0) begin : g_first
         assign rem_src  = num_in[DW+QW-1:QW];
         assign low_src  = num_in[QW-1:0];
         assign den_src  = den_in;
         assign quot_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign low_src  = low_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign quot_src = quot_ff[s-1];
      end

      always_comb begin
         logic [DW:0] trial;
         rem_in  = rem_src;
         quot_in = quot_src;
         for (int j = 0; j < STEP; j++) begin
            if (s * STEP + j < QW) begin
               trial = {rem_in, low_src[QW-1-(s*STEP+j)]};
               if (trial >= {1'b0, den_src}) begin
                  trial = trial - {1'b0, den_src};
                  quot_in[QW-1-(s*STEP+j)] = 1'b1;
               end
               rem_in = trial[DW-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_src;
            low_ff[s]  <= low_src;
            quot_ff[s] <= quot_in;
         end
      end
   end

   assign quot_out = quot_ff[STAGES-1];

endmodule

`default_nettype wire

@@ design/affine_grid_point_generator.sv @@
// ----------------------------------------------------------------------------
// Affine grid point generator
// Loads a 2x3 or 3x4 fixed-point affine matrix and maps grid indices to
// normalized, transformed and saturated sampling coordinates.
// ----------------------------------------------------------------------------
// Pipeline: front stage, divider stages, product, sum and result registers (Q16.16 at the default FRAC_BITS).
// Throughput: one transaction per cycle unless the result stalls; the pipeline depth is set by the
// two-bit-per-stage divider that forms the normalized base coordinates.
// A stalled result freezes the whole pipeline. Synchronous reset clears the
// valid bits and the matrix coefficients and resets the configuration registers.
`default_nettype none

module affine_grid_point_generator #(
   parameter int MAX_DIM   = afg_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = afg_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [afg_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [afg_pkg::CSR_DATA_W-1:0]         csr_write_data,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_func,
   input  wire logic [afg_pkg::COEF_IDX_W-1:0]         req_coef_index,
   input  wire logic signed [afg_pkg::COEF_W-1:0]      req_coef_value,
   input  wire logic [afg_pkg::IDX_W-1:0]              req_col_index,
   input  wire logic [afg_pkg::IDX_W-1:0]              req_row_index,
   input  wire logic [afg_pkg::IDX_W-1:0]              req_slice_index,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [afg_pkg::COEF_W-1:0]           rsp_coord_x,
   output logic signed [afg_pkg::COEF_W-1:0]           rsp_coord_y,
   output logic signed [afg_pkg::COEF_W-1:0]           rsp_coord_z,
   output logic                                        rsp_index_error
);

   localparam int SW     = afg_pkg::SIZE_W;
   localparam int CW     = afg_pkg::COEF_W;
   localparam int NA     = afg_pkg::NUM_AXES;
   localparam int QW     = FRAC_BITS + 1;
   localparam int DW     = SW + 1;
   localparam int NWID   = DW + QW;
   localparam int STEP   = 2;
   localparam int STAGES = (QW + STEP - 1) / STEP;
   localparam int BW     = QW + 1;
   localparam int PW     = CW + BW;
   localparam int AW     = PW + 3;

   typedef struct packed {
      logic [NWID-1:0] num;
      logic [DW-1:0]   den;
      logic            neg;
      logic            one;
      logic            err;
   } axis_type;

   // Configuration registers.
   logic          three_d_ff;
   logic          align_ff;
   logic [SW-1:0] size_ff[NA];

   always_ff @(posedge clock) begin
      if (reset) begin
         three_d_ff <= 1'b0;
         align_ff   <= 1'b0;
         for (int k = 0; k < NA; k++) size_ff[k] <= SW'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            afg_pkg::CSR_THREE_D:       three_d_ff <= csr_write_data[0];
            afg_pkg::CSR_ALIGN_CORNERS: align_ff   <= csr_write_data[0];
            afg_pkg::CSR_WIDTH:         size_ff[0] <= csr_write_data[SW-1:0];
            afg_pkg::CSR_HEIGHT:        size_ff[1] <= csr_write_data[SW-1:0];
            afg_pkg::CSR_DEPTH:         size_ff[2] <= csr_write_data[SW-1:0];
            default: ;
         endcase
      end
   end

   // Numerator and divisor of round(|2i+1-n| * 2^F / d), d = n or n-1.
   // Rounding to nearest comes from dividing (a*2^(F+1) + d) by 2d.
   function automatic axis_type prep_axis(logic [afg_pkg::IDX_W-1:0] idx,
                                          logic [SW-1:0] n_raw, logic align);
      logic [SW-1:0]          n;
      logic [SW-1:0]          d;
      logic signed [SW+1:0]   diff;
      logic [SW+1:0]          mag;
      axis_type               res;
      n        = (32'(n_raw) > MAX_DIM) ? SW'(MAX_DIM) : n_raw;
      res.err  = (SW'(idx) >= n);
      diff     = $signed({1'b0, idx, 1'b1}) - $signed({2'b00, n});
      res.neg  = diff[SW+1];
      mag      = res.neg ? (SW+2)'(-diff) : diff;
      d        = align ? n - SW'(1) : n;
      res.one  = align && (n == SW'(1));
      if (d == '0) d = SW'(1);
      res.num  = NWID'({mag[SW-1:0], {QW{1'b0}}}) + NWID'(d);
      res.den  = {d, 1'b0};
      return res;
   endfunction

   logic en;
   logic req_accept;

   assign en         = !(rsp_valid && rsp_stall);
   assign req_stall  = !en;
   assign req_accept = req_valid && en;

   // Front stage.
   logic [afg_pkg::IDX_W-1:0] idx_sel[NA];
   axis_type                  axis_in[NA];
   axis_type                  axis_ff[NA];
   afg_pkg::side_type         side_in;
   afg_pkg::side_type         side_ff[STAGES+1];

   assign idx_sel[0] = req_col_index;
   assign idx_sel[1] = req_row_index;
   assign idx_sel[2] = req_slice_index;

   always_comb begin
      for (int k = 0; k < NA; k++) axis_in[k] = prep_axis(idx_sel[k], size_ff[k], align_ff);
      side_in.valid      = req_accept;
      side_in.func       = afg_pkg::func_type'(req_func);
      side_in.err        = axis_in[0].err || axis_in[1].err || (three_d_ff && axis_in[2].err);
      for (int k = 0; k < NA; k++) begin
         side_in.one[k] = axis_in[k].one;
         side_in.neg[k] = axis_in[k].neg;
      end
      side_in.coef_index = req_coef_index;
      side_in.coef_value = req_coef_value;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NA; k++) axis_ff[k] <= axis_in[k];
      end
   end

   // Side band travels alongside the divider stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STAGES; s++) side_ff[s].valid <= 1'b0;
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s <= STAGES; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   logic [QW-1:0] quot[NA];

   for (genvar k = 0; k < NA; k++) begin : g_axis
      afg_div #(
         .QW   (QW),
         .DW   (DW),
         .STEP (STEP)
      ) u_div (
         .clock    (clock),
         .en       (en),
         .num_in   (axis_ff[k].num),
         .den_in   (axis_ff[k].den),
         .quot_out (quot[k])
      );
   end

   // Coefficient file; a load is applied in order with the points around it.
   afg_pkg::side_type        div_side;
   logic signed [CW-1:0]     theta_ff[afg_pkg::NUM_COEF];
   logic                     theta_we;

   assign div_side = side_ff[STAGES];
   assign theta_we = en && div_side.valid && (div_side.func == afg_pkg::FUNC_LOAD)
                     && (div_side.coef_index < afg_pkg::COEF_IDX_W'(afg_pkg::NUM_COEF));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < afg_pkg::NUM_COEF; k++) theta_ff[k] <= '0;
      end else if (theta_we) begin
         theta_ff[div_side.coef_index] <= div_side.coef_value;
      end
   end

   // Product stage.
   logic signed [BW-1:0] base[NA];
   logic signed [CW-1:0] mcoef[NA][NA];
   logic signed [CW-1:0] trans[NA];
   logic signed [PW-1:0] prod_ff[NA][NA];
   logic signed [CW-1:0] trans_ff[NA];
   logic                 p_valid_ff, p_point_ff, p_err_ff;

   always_comb begin
      logic [BW-1:0] mag;
      for (int k = 0; k < NA; k++) begin
         mag     = div_side.one[k] ? BW'(1) << FRAC_BITS : BW'(quot[k]);
         base[k] = div_side.neg[k] ? -$signed(mag) : $signed(mag);
      end
      if (!three_d_ff) base[2] = '0;
      for (int r = 0; r < NA; r++) begin
         for (int c = 0; c < NA; c++) begin
            if (three_d_ff) mcoef[r][c] = theta_ff[4*r+c];
            else if (r < 2 && c < 2) mcoef[r][c] = theta_ff[3*r+c];
            else mcoef[r][c] = '0;
         end
         if (three_d_ff) trans[r] = theta_ff[4*r+3];
         else if (r < 2) trans[r] = theta_ff[3*r+2];
         else trans[r] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < NA; r++) begin
            for (int c = 0; c < NA; c++) prod_ff[r][c] <= PW'(mcoef[r][c]) * PW'(base[c]);
            trans_ff[r] <= trans[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= div_side.valid;
         p_point_ff <= (div_side.func == afg_pkg::FUNC_POINT);
         p_err_ff   <= div_side.err;
      end
   end

   // Sum stage: exact sum plus half an output step.
   logic signed [AW-1:0] acc_ff[NA];
   logic                 a_valid_ff, a_err_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < NA; r++) begin
            acc_ff[r] <= AW'(prod_ff[r][0]) + AW'(prod_ff[r][1]) + AW'(prod_ff[r][2])
                         + (AW'(trans_ff[r]) <<< FRAC_BITS)
                         + (AW'(1) <<< (FRAC_BITS - 1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= p_valid_ff && p_point_ff;
         a_err_ff   <= p_err_ff;
      end
   end

   // Round toward minus infinity after the half offset, then saturate; an index error gives zero.
   logic signed [CW-1:0] coord_in[NA];

   always_comb begin
      logic signed [AW-1:0] q;
      for (int r = 0; r < NA; r++) begin
         q = acc_ff[r] >>> FRAC_BITS;
         if (a_err_ff) coord_in[r] = '0;
         else if (q > $signed(AW'(32'h7FFF_FFFF))) coord_in[r] = 32'sh7FFF_FFFF;
         else if (q < $signed({{(AW-CW){1'b1}}, 32'h8000_0000})) coord_in[r] = 32'sh8000_0000;
         else coord_in[r] = q[CW-1:0];
      end
   end

   logic                 rsp_valid_ff;
   logic signed [CW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                 rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= a_valid_ff;
         rsp_x_ff     <= coord_in[0];
         rsp_y_ff     <= coord_in[1];
         rsp_z_ff     <= coord_in[2];
         rsp_err_ff   <= a_err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coord_x     = rsp_x_ff;
   assign rsp_coord_y     = rsp_y_ff;
   assign rsp_coord_z     = rsp_z_ff;
   assign rsp_index_error = rsp_err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> rsp_coord_x == '0 && rsp_coord_y == '0
                                       && rsp_coord_z == '0)
      else $error("index error transaction carries nonzero coordinates");

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output backpressure");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      en && div_side.valid && div_side.func == afg_pkg::FUNC_LOAD |=> !p_point_ff)
      else $error("coefficient load turned into a point");

endmodule

`default_nettype wire

@@ tb/sv/affine_grid_point_generator_tb.sv @@
// ----------------------------------------------------------------------------
// Affine grid point generator testbench
// Loads affine coefficients and streams grid points through the block under
// random sender bursts and receiver stalls. A built-in fixed-point predictor
// forms each expected coordinate set, and every result transaction is
// compared field by field in order. Directed rows cover the extremes, the
// index error and the ignored writes; random phases sweep the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_grid_point_generator_tb;

   localparam int CSR_IDX_W     = afg_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W    = afg_pkg::CSR_DATA_W;
   localparam int COEF_IDX_W    = afg_pkg::COEF_IDX_W;
   localparam int COEF_W        = afg_pkg::COEF_W;
   localparam int IDX_W         = afg_pkg::IDX_W;
   localparam int SIZE_W        = afg_pkg::SIZE_W;
   localparam int NUM_COEF      = afg_pkg::NUM_COEF;
   localparam int MAX_DIM_DEF   = afg_pkg::MAX_DIM_DEF;
   localparam int FRAC_BITS_DEF = afg_pkg::FRAC_BITS_DEF;

   localparam int                   HALF_PERIOD = 4;
   localparam int                   DRAIN_CYCLES = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [COEF_IDX_W-1:0] COEF_IDX_BAD = 4'd15;
   localparam longint               ONE_Q = 64'sd1 <<< FRAC_BITS_DEF;

   typedef struct {
      logic signed [COEF_W-1:0] x;
      logic signed [COEF_W-1:0] y;
      logic signed [COEF_W-1:0] z;
      logic                     err;
   } grid_point_type;

   typedef enum {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      afg_pkg::func_type      func;
      logic [COEF_IDX_W-1:0]  cidx;
      logic [COEF_W-1:0]      cval;
      logic [IDX_W-1:0]       col;
      logic [IDX_W-1:0]       row;
      logic [IDX_W-1:0]       slc;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic [CSR_DATA_W-1:0]  reg_data;
      bit                     has_exp;
      grid_point_type         exp_pt;
   } dir_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_write_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_func = 1'b0;
   logic [COEF_IDX_W-1:0]         req_coef_index = '0;
   logic signed [COEF_W-1:0]      req_coef_value = '0;
   logic [IDX_W-1:0]              req_col_index = '0;
   logic [IDX_W-1:0]              req_row_index = '0;
   logic [IDX_W-1:0]              req_slice_index = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [COEF_W-1:0]      rsp_coord_x;
   logic signed [COEF_W-1:0]      rsp_coord_y;
   logic signed [COEF_W-1:0]      rsp_coord_z;
   logic                          rsp_index_error;

   affine_grid_point_generator u_top (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_coef_index(req_coef_index), .req_coef_value(req_coef_value),
      .req_col_index(req_col_index), .req_row_index(req_row_index),
      .req_slice_index(req_slice_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_coord_x(rsp_coord_x), .rsp_coord_y(rsp_coord_y),
      .rsp_coord_z(rsp_coord_z), .rsp_index_error(rsp_index_error)
   );

   always #HALF_PERIOD clock = ~clock;

   // Predictor state: matrix and register copies.
   logic signed [COEF_W-1:0] theta [NUM_COEF];
   logic                     mode_3d;
   logic                     align;
   logic [SIZE_W-1:0]        size_w;
   logic [SIZE_W-1:0]        size_h;
   logic [SIZE_W-1:0]        size_d;

   grid_point_type expected_points[$];
   int             mismatches = 0;
   int             burst_left = 0;

   function automatic int clamp_size(logic [SIZE_W-1:0] n);
      return (n > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(n);
   endfunction

   // Normalized base coordinate, quotient rounded half away from zero.
   function automatic longint norm_coord(int i, int n);
      longint num;
      longint den;
      if (align) begin
         if (n == 1) return ONE_Q;
         num = (2 * longint'(i) - (n - 1)) * ONE_Q;
         den = n - 1;
      end else begin
         num = (2 * longint'(i) + 1 - n) * ONE_Q;
         den = n;
      end
      if (num >= 0) return (2 * num + den) / (2 * den);
      return -((-2 * num + den) / (2 * den));
   endfunction

   // Round once with ties toward plus infinity, then saturate.
   function automatic logic signed [COEF_W-1:0] round_sat(longint acc);
      longint q;
      q = (acc + (ONE_Q >>> 1)) >>> FRAC_BITS_DEF;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[COEF_W-1:0];
   endfunction

   function automatic logic signed [COEF_W-1:0] matrix_row(int first, longint b [3], int nb);
      longint acc;
      acc = 0;
      for (int c = 0; c < nb; c++) acc += longint'(theta[first + c]) * b[c];
      acc += longint'(theta[first + nb]) * ONE_Q;
      return round_sat(acc);
   endfunction

   function automatic grid_point_type transform_point(int ci, int rj, int sk);
      grid_point_type p;
      longint         b [3];
      int             nw;
      int             nh;
      int             nd;
      nw = clamp_size(size_w);
      nh = clamp_size(size_h);
      nd = clamp_size(size_d);
      p = '{x: '0, y: '0, z: '0, err: 1'b0};
      p.err = (ci >= nw) || (rj >= nh) || (mode_3d && sk >= nd);
      if (p.err) return p;
      b[0] = norm_coord(ci, nw);
      b[1] = norm_coord(rj, nh);
      b[2] = 0;
      if (mode_3d) begin
         b[2] = norm_coord(sk, nd);
         p.x = matrix_row(0, b, 3);
         p.y = matrix_row(4, b, 3);
         p.z = matrix_row(8, b, 3);
      end else begin
         p.x = matrix_row(0, b, 2);
         p.y = matrix_row(3, b, 2);
      end
      return p;
   endfunction

   task automatic report(string what, logic [COEF_W-1:0] got, logic [COEF_W-1:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Result checker.
   always @(posedge clock) begin
      grid_point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            report("unexpected result", rsp_coord_x, '0);
         end else begin
            e = expected_points.pop_front();
            if (rsp_coord_x !== e.x) report("coord_x", rsp_coord_x, e.x);
            if (rsp_coord_y !== e.y) report("coord_y", rsp_coord_y, e.y);
            if (rsp_coord_z !== e.z) report("coord_z", rsp_coord_z, e.z);
            if (rsp_index_error !== e.err)
               report("index_error", 32'(rsp_index_error), 32'(e.err));
         end
      end
   end

   // Receiver stall pattern, its mode redrawn at random when the low byte of a free-running counter is all ones.
   int unsigned stall_mode = 0;
   int unsigned stall_count = 0;
   always @(posedge clock) begin
      stall_count <= stall_count + 1;
      if (stall_count[7:0] == 8'hff) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         2: rsp_stall <= ($urandom_range(0, 9) < 8);
         default: rsp_stall <= (stall_count[2:0] == 3'd5);
      endcase
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         afg_pkg::CSR_THREE_D:       mode_3d = data[0];
         afg_pkg::CSR_ALIGN_CORNERS: align = data[0];
         afg_pkg::CSR_WIDTH:         size_w = data;
         afg_pkg::CSR_HEIGHT:        size_h = data;
         afg_pkg::CSR_DEPTH:         size_d = data;
         default: ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(afg_pkg::func_type f, logic [COEF_IDX_W-1:0] ci,
                            logic [COEF_W-1:0] cv,
                            logic [IDX_W-1:0] col, logic [IDX_W-1:0] row,
                            logic [IDX_W-1:0] slc, bit has_exp, grid_point_type exp_pt);
      grid_point_type p;
      req_valid <= 1'b1;
      req_func <= f;
      req_coef_index <= ci;
      req_coef_value <= cv;
      req_col_index <= col;
      req_row_index <= row;
      req_slice_index <= slc;
      do @(posedge clock); while (req_stall);
      if (f == afg_pkg::FUNC_LOAD) begin
         if (ci < NUM_COEF) theta[ci] = cv;
      end else begin
         p = transform_point(int'(col), int'(row), int'(slc));
         expected_points.push_back(has_exp ? exp_pt : p);
      end
      // Bursts of back-to-back transactions separated by random gaps.
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   function automatic dir_row_type csr_row(logic [CSR_IDX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] d);
      dir_row_type r;
      r = '{kind: ROW_CSR, func: afg_pkg::FUNC_LOAD, cidx: '0, cval: '0, col: '0,
            row: '0, slc: '0, reg_idx: idx, reg_data: d, has_exp: 1'b0,
            exp_pt: '{x: '0, y: '0, z: '0, err: 1'b0}};
      return r;
   endfunction

   function automatic dir_row_type load_row(logic [COEF_IDX_W-1:0] ci, logic [COEF_W-1:0] cv);
      dir_row_type r;
      r = csr_row('0, '0);
      r.kind = ROW_ITEM;
      r.cidx = ci;
      r.cval = cv;
      return r;
   endfunction

   function automatic dir_row_type point_row(int c, int rw, int s, bit has, logic err);
      dir_row_type r;
      r = csr_row('0, '0);
      r.kind = ROW_ITEM;
      r.func = afg_pkg::FUNC_POINT;
      r.col = IDX_W'(c);
      r.row = IDX_W'(rw);
      r.slc = IDX_W'(s);
      r.has_exp = has;
      r.exp_pt.err = err;
      return r;
   endfunction

   function automatic int pick_index(logic [SIZE_W-1:0] n);
      int en;
      en = clamp_size(n);
      if (en == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
      return $urandom_range(0, en - 1);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_size();
      case ($urandom_range(0, 11))
         0: return 11'd1;
         1: return 11'd1024;
         2: return CSR_DATA_W'($urandom_range(1025, 2047));
         3: return 11'd0;
         4: return CSR_DATA_W'($urandom_range(1, 2047));
         default: return CSR_DATA_W'($urandom_range(2, 12));
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      endcase
   endfunction

   initial begin
      dir_row_type    rows[$];
      grid_point_type none;
      logic [COEF_IDX_W-1:0] ci;
      none = '{x: '0, y: '0, z: '0, err: 1'b0};
      foreach (theta[k]) theta[k] = '0;
      mode_3d = 1'b0;
      align = 1'b0;
      size_w = 11'd1;
      size_h = 11'd1;
      size_d = 11'd1;

      // After reset: a zero matrix and sizes of one.
      rows.push_back(point_row(0, 0, 0, 1, 1'b0));
      rows.push_back(point_row(1, 0, 0, 1, 1'b1));
      rows.push_back(point_row(1023, 1023, 1023, 1, 1'b1));
      rows.push_back(load_row(4'd0, 32'h7fffffff));
      rows.push_back(load_row(4'd1, 32'h80000000));
      rows.push_back(load_row(4'd2, 32'h7fffffff));
      rows.push_back(load_row(4'd3, 32'h00010000));
      rows.push_back(load_row(4'd4, 32'hffff0000));
      rows.push_back(load_row(4'd5, 32'h80000000));
      rows.push_back(load_row(4'd11, 32'h7fffffff));
      rows.push_back(load_row(4'd12, 32'h12345678));
      rows.push_back(load_row(COEF_IDX_BAD, 32'hdeadbeef));
      rows.push_back(csr_row(afg_pkg::CSR_WIDTH, 11'd1024));
      rows.push_back(csr_row(afg_pkg::CSR_HEIGHT, 11'd2047));
      rows.push_back(csr_row(afg_pkg::CSR_ALIGN_CORNERS, 11'd1));
      rows.push_back(point_row(0, 0, 0, 0, 1'b0));
      rows.push_back(point_row(1023, 1023, 0, 0, 1'b0));
      rows.push_back(point_row(512, 3, 0, 0, 1'b0));
      rows.push_back(csr_row(afg_pkg::CSR_THREE_D, 11'd1));
      rows.push_back(csr_row(afg_pkg::CSR_DEPTH, 11'd0));
      rows.push_back(point_row(0, 0, 0, 1, 1'b1));
      rows.push_back(csr_row(afg_pkg::CSR_DEPTH, 11'd5));
      rows.push_back(csr_row(CSR_UNUSED, 11'd7));
      rows.push_back(point_row(1023, 0, 4, 0, 1'b0));
      rows.push_back(point_row(0, 1023, 5, 1, 1'b1));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[n]) begin
         if (rows[n].kind == ROW_CSR) begin
            wait_idle();
            write_reg(rows[n].reg_idx, rows[n].reg_data);
         end else begin
            send_item(rows[n].func, rows[n].cidx, rows[n].cval, rows[n].col, rows[n].row,
                      rows[n].slc, rows[n].has_exp, rows[n].exp_pt);
         end
      end

      for (int phase = 0; phase < 12; phase++) begin
         wait_idle();
         write_reg(afg_pkg::CSR_THREE_D, CSR_DATA_W'($urandom_range(0, 2047)));
         write_reg(afg_pkg::CSR_ALIGN_CORNERS, CSR_DATA_W'($urandom_range(0, 2047)));
         write_reg(afg_pkg::CSR_WIDTH, (phase == 1) ? 11'd1024 : pick_size());
         write_reg(afg_pkg::CSR_HEIGHT, (phase == 1) ? 11'd2047 : pick_size());
         write_reg(afg_pkg::CSR_DEPTH, (phase == 2) ? 11'd1 : pick_size());
         if ($urandom_range(0, 2) == 0)
            write_reg(CSR_IDX_W'($urandom_range(5, 7)), CSR_DATA_W'($urandom));
         for (int n = 0; n < 125; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               ci = ($urandom_range(0, 9) == 0) ? COEF_IDX_W'($urandom_range(12, 15))
                                                 : COEF_IDX_W'($urandom_range(0, 11));
               send_item(afg_pkg::FUNC_LOAD, ci, pick_coef(), IDX_W'($urandom),
                         IDX_W'($urandom), IDX_W'($urandom), 0, none);
            end else begin
               send_item(afg_pkg::FUNC_POINT, COEF_IDX_W'($urandom), $urandom,
                         IDX_W'(pick_index(size_w)), IDX_W'(pick_index(size_h)),
                         IDX_W'(pick_index(size_d)), 0, none);
            end
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #(2 * HALF_PERIOD * 1000000);
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
design/afg_pkg.sv
design/afg_div.sv
design/affine_grid_point_generator.sv
tb/sv/affine_grid_point_generator_tb.sv
